// File: design/i128x87_pkg.sv
package i128x87_pkg;

    typedef enum logic [1:0] {
        FUNC_U2F = 2'd0,
        FUNC_S2F = 2'd1,
        FUNC_F2U = 2'd2,
        FUNC_F2S = 2'd3
    } func_t;

    localparam logic [14:0] EXP_BIAS = 15'd16383;
    localparam logic [14:0] EXP_MAX  = 15'h7FFF;
    localparam logic [63:0] TOP_BIT  = 64'h8000000000000000;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] int_high;
        logic [63:0] int_low;
        logic        fp_sign;
        logic [14:0] fp_exponent;
        logic [63:0] fp_mantissa;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] res_int_high;
        logic [63:0] res_int_low;
        logic        res_sign;
        logic [14:0] res_exponent;
        logic [63:0] res_mantissa;
    } out_beat_t;

endpackage

// File: design/i128x87_to_float.sv
module i128x87_to_float
(
    input  logic [127:0] value,
    input  logic         signed_op,
    output logic         sign,
    output logic [14:0]  exponent,
    output logic [63:0]  mantissa
);

    logic [127:0] mag;
    logic [127:0] norm;
    logic [6:0]   top;
    logic         found;
    logic         round_up;
    logic [64:0]  sum;

    always_comb
    begin
        sign = signed_op & value[127];
        mag  = sign ? (~value + 128'd1) : value;
        top   = 7'd0;
        found = 1'b0;
        for (int i = 127; i >= 0; i--)
        begin
            if (!found && mag[i])
            begin
                top   = 7'(i);
                found = 1'b1;
            end
        end
        norm     = mag << (7'd127 - top);
        round_up = (norm[63:0] > i128x87_pkg::TOP_BIT)
                 || (norm[63:0] == i128x87_pkg::TOP_BIT && norm[64]);
        sum      = {1'b0, norm[127:64]} + {64'd0, round_up};
        if (!found)
        begin
            exponent = 15'd0;
            mantissa = 64'd0;
        end
        else if (sum[64])
        begin
            exponent = i128x87_pkg::EXP_BIAS + {8'd0, top} + 15'd1;
            mantissa = i128x87_pkg::TOP_BIT;
        end
        else
        begin
            exponent = i128x87_pkg::EXP_BIAS + {8'd0, top};
            mantissa = sum[63:0];
        end
    end

endmodule

// File: design/i128x87_to_int.sv
module i128x87_to_int
(
    input  logic         signed_op,
    input  logic         sign,
    input  logic [14:0]  exponent,
    input  logic [63:0]  mantissa,
    output logic [127:0] result
);

    logic         is_inf;
    logic         is_nan;
    logic         ge_one;
    logic [14:0]  k;
    logic [190:0] wide;
    logic [127:0] mag;

    always_comb
    begin
        is_inf = (exponent == i128x87_pkg::EXP_MAX) && (mantissa == i128x87_pkg::TOP_BIT);
        is_nan = ((exponent == i128x87_pkg::EXP_MAX) && (mantissa != i128x87_pkg::TOP_BIT))
              || ((exponent != 15'd0) && (exponent != i128x87_pkg::EXP_MAX)
                  && !mantissa[63]);
        ge_one = exponent >= i128x87_pkg::EXP_BIAS;
        k      = exponent - i128x87_pkg::EXP_BIAS;
        wide   = {127'd0, mantissa} << k[6:0];
        mag    = wide[190:63];
        if (is_nan)
            result = 128'd0;
        else if (!signed_op)
        begin
            if (sign || !ge_one)
                result = 128'd0;
            else if (is_inf || k >= 15'd128)
                result = '1;
            else
                result = mag;
        end
        else
        begin
            if (is_inf || (ge_one && k >= 15'd127))
                result = sign ? {1'b1, 127'd0} : {1'b0, {127{1'b1}}};
            else if (!ge_one)
                result = 128'd0;
            else
                result = sign ? (~mag + 128'd1) : mag;
        end
    end

endmodule

// File: design/int128_x87_extended_convert_core.sv
// int128 <-> x87 80-bit extended converter
// in channel: in_valid/in_ready carry one in_beat (func, integer and float operand)
// out channel: out_valid/out_ready carry one out_beat with integer and float results
// func 0/1: unsigned/signed integer to float, round to nearest even
// func 2/3: float to unsigned/signed integer, truncating and saturating
// fields unused by the selected func read as zero
// a beat passes through the input register and then the result register
// throughput: one beat per cycle while the receiver is ready, set by the input register and result register
// the conversion logic between them is one combinational pass
// a stalled receiver holds the result register; the input register still
// advances while the result register is empty or being drained
// reset clears both valid flags; no beat is held after reset
module int128_x87_extended_convert_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  i128x87_pkg::in_beat_t  in_beat,
    output logic                   out_valid,
    input  logic                   out_ready,
    output i128x87_pkg::out_beat_t out_beat
);

    i128x87_pkg::in_beat_t  op_reg;
    logic                   op_valid_reg;
    i128x87_pkg::out_beat_t res_reg;
    logic                   res_valid_reg;
    i128x87_pkg::out_beat_t res_next;
    logic                   advance;
    logic                   f_sign;
    logic [14:0]            f_exp;
    logic [63:0]            f_mant;
    logic [127:0]           i_res;
    logic                   to_float;

    assign advance   = !res_valid_reg || out_ready;
    assign in_ready  = !op_valid_reg || advance;
    assign out_valid = res_valid_reg;
    assign out_beat  = res_reg;
    assign to_float  = (op_reg.func == i128x87_pkg::FUNC_U2F)
                    || (op_reg.func == i128x87_pkg::FUNC_S2F);

    i128x87_to_float u_to_float
    (
        .value     ({op_reg.int_high, op_reg.int_low}),
        .signed_op (op_reg.func == i128x87_pkg::FUNC_S2F),
        .sign      (f_sign),
        .exponent  (f_exp),
        .mantissa  (f_mant)
    );

    i128x87_to_int u_to_int
    (
        .signed_op (op_reg.func == i128x87_pkg::FUNC_F2S),
        .sign      (op_reg.fp_sign),
        .exponent  (op_reg.fp_exponent),
        .mantissa  (op_reg.fp_mantissa),
        .result    (i_res)
    );

    always_comb
    begin
        if (to_float)
            res_next = '{res_int_high: 64'd0, res_int_low: 64'd0, res_sign: f_sign,
                         res_exponent: f_exp, res_mantissa: f_mant};
        else
            res_next = '{res_int_high: i_res[127:64], res_int_low: i_res[63:0],
                         res_sign: 1'b0, res_exponent: 15'd0, res_mantissa: 64'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                op_valid_reg <= in_valid;
            if (advance)
                res_valid_reg <= op_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            op_reg <= in_beat;
        if (advance && op_valid_reg)
            res_reg <= res_next;
    end

endmodule
